// ===== hdl/kmeans_lloyd_clustering_macros.svh =====
// assertion macros for the k-means clustering top level
`ifndef KMEANS_LLOYD_CLUSTERING_MACROS_SVH
`define KMEANS_LLOYD_CLUSTERING_MACROS_SVH

// same-cycle implication, checked outside reset
`define KMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define KMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/kmc_pkg.sv =====
// shared types and constants for the k-means clustering block
`timescale 1ns / 1ps
package kmc_pkg;

    localparam int COORD_W = 24;
    localparam int SUM_W   = 40;
    localparam int DIST_W  = 53;
    localparam int IDX_W   = 3;

    localparam logic [1:0] OP_POINT = 2'd0;
    localparam logic [1:0] OP_CENT  = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    localparam logic [1:0] REG_NUM_POINTS = 2'd0;
    localparam logic [1:0] REG_NUM_CLUST  = 2'd1;
    localparam logic [1:0] REG_NUM_DIMS   = 2'd2;
    localparam logic [1:0] REG_MAX_ITER   = 2'd3;

    // coordinate travelling down the cell chain
    typedef struct packed {
        logic               valid;
        logic               mode_sum;
        logic               last;
        logic [IDX_W-1:0]   dim;
        logic [IDX_W-1:0]   tag;
        logic [COORD_W-1:0] coord;
    } t_link;

    // best centroid so far for the point in flight
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] sq_dist;
        logic [IDX_W-1:0]  idx;
    } t_best;

    // centroid coordinate write into one cell
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   dim;
        logic [COORD_W-1:0] val;
    } t_cwr;

endpackage

// ===== hdl/kmc_cell.sv =====
// one centroid cell: distance, compare-and-forward, per-cluster sums
`timescale 1ns / 1ps
module kmc_cell #(
    parameter int CELL_IDX = 0,
    parameter int MAX_DIMS = 8,
    parameter int CNT_W    = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_active,
    input  logic                         i_clear,
    input  kmc_pkg::t_link               i_link,
    output kmc_pkg::t_link               o_link,
    input  kmc_pkg::t_best               i_best,
    output kmc_pkg::t_best               o_best,
    input  kmc_pkg::t_cwr                i_cwr,
    input  logic [kmc_pkg::IDX_W-1:0]    i_rd_dim,
    output logic [kmc_pkg::COORD_W-1:0] o_cent,
    output logic [kmc_pkg::SUM_W-1:0]   o_sum,
    output logic [CNT_W-1:0]             o_count
);

    localparam int DIM_IW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SQ_W   = 2 * (kmc_pkg::COORD_W + 1);

    logic [kmc_pkg::COORD_W-1:0] r_cent [MAX_DIMS];
    logic [kmc_pkg::SUM_W-1:0]   r_sum  [MAX_DIMS];
    logic [CNT_W-1:0]            r_count;

    kmc_pkg::t_link r_link;
    kmc_pkg::t_best r_best;

    logic                        r_s1_valid;
    logic                        r_s1_first;
    logic                        r_s1_last;
    logic [SQ_W-1:0]             r_sq;
    logic [kmc_pkg::DIST_W-1:0]  r_acc;

    logic [DIM_IW-1:0]           w_rd_a;
    logic [kmc_pkg::COORD_W-1:0] w_cent_rd;
    logic [kmc_pkg::SUM_W-1:0]   w_sum_rd;
    logic signed [kmc_pkg::COORD_W:0] w_diff;
    logic signed [SQ_W-1:0]      w_prod;
    logic [kmc_pkg::DIST_W-1:0]  w_dist;
    logic                        w_take;
    logic                        w_mine;

    // chain traffic owns the array port while it flows, the sequencer otherwise
    assign w_rd_a    = i_link.valid ? i_link.dim[DIM_IW-1:0] : i_rd_dim[DIM_IW-1:0];
    assign w_cent_rd = r_cent[w_rd_a];
    assign w_sum_rd  = r_sum[w_rd_a];

    assign w_diff = $signed({i_link.coord[kmc_pkg::COORD_W-1], i_link.coord})
                  - $signed({w_cent_rd[kmc_pkg::COORD_W-1], w_cent_rd});
    assign w_prod = w_diff * w_diff;

    assign w_dist = r_s1_first ? {{(kmc_pkg::DIST_W-SQ_W){1'b0}}, r_sq}
                               : r_acc + {{(kmc_pkg::DIST_W-SQ_W){1'b0}}, r_sq};
    // strict less keeps the lower index on ties
    assign w_take = i_active && (!i_best.valid || (w_dist < i_best.sq_dist));
    assign w_mine = i_link.valid && i_link.mode_sum
                 && (i_link.tag == kmc_pkg::IDX_W'(CELL_IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link.valid <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_best.valid <= 1'b0;
        end else begin
            r_link.valid <= i_link.valid;
            r_s1_valid   <= i_link.valid && !i_link.mode_sum;
            r_best.valid <= r_s1_valid && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link.mode_sum <= i_link.mode_sum;
        r_link.last     <= i_link.last;
        r_link.dim      <= i_link.dim;
        r_link.tag      <= i_link.tag;
        r_link.coord    <= i_link.coord;
        r_s1_first      <= (i_link.dim == '0);
        r_s1_last       <= i_link.last;
        r_sq            <= w_prod;
        if (r_s1_valid) begin
            r_acc <= w_dist;
        end
        if (r_s1_valid && r_s1_last) begin
            if (w_take) begin
                r_best.sq_dist <= w_dist;
                r_best.idx     <= kmc_pkg::IDX_W'(CELL_IDX);
            end else begin
                r_best.sq_dist <= i_best.sq_dist;
                r_best.idx     <= i_best.idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            for (int i = 0; i < MAX_DIMS; i++) begin
                r_sum[i] <= '0;
            end
            r_count <= '0;
        end else if (w_mine) begin
            r_sum[w_rd_a] <= w_sum_rd
                + {{(kmc_pkg::SUM_W-kmc_pkg::COORD_W){i_link.coord[kmc_pkg::COORD_W-1]}},
                   i_link.coord};
            if (i_link.last) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
        if (i_cwr.en && (i_cwr.idx == kmc_pkg::IDX_W'(CELL_IDX))) begin
            r_cent[i_cwr.dim[DIM_IW-1:0]] <= i_cwr.val;
        end
    end

    assign o_link  = r_link;
    assign o_best  = r_best;
    assign o_cent  = w_cent_rd;
    assign o_sum   = w_sum_rd;
    assign o_count = r_count;

endmodule

// ===== hdl/kmc_div.sv =====
// restoring divider: signed sum over unsigned count, truncating toward zero
`timescale 1ns / 1ps
module kmc_div #(
    parameter int CNT_W = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [kmc_pkg::SUM_W-1:0]   i_dividend,
    input  logic [CNT_W-1:0]             i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [kmc_pkg::COORD_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(kmc_pkg::SUM_W + 1);

    logic                        r_busy;
    logic                        r_done;
    logic                        r_neg;
    logic [kmc_pkg::SUM_W-1:0]   r_num;
    logic [CNT_W-1:0]            r_rem;
    logic [CNT_W-1:0]            r_div;
    logic [STEP_W-1:0]           r_step;

    logic [CNT_W:0]              w_rem_sh;
    logic                        w_ge;
    logic [CNT_W:0]              w_rem_nx;

    assign w_rem_sh = {r_rem, r_num[kmc_pkg::SUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == STEP_W'(kmc_pkg::SUM_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_dividend[kmc_pkg::SUM_W-1];
            r_num  <= i_dividend[kmc_pkg::SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
            r_step <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[kmc_pkg::SUM_W-2:0], w_ge};
            r_rem  <= w_rem_nx[CNT_W-1:0];
            r_step <= r_step + STEP_W'(1);
        end
    end

    // quotient bits sit in r_num once the shifts are done, sign applied here
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_num[kmc_pkg::COORD_W-1:0] + 1'b1)
                          : r_num[kmc_pkg::COORD_W-1:0];

endmodule

// ===== hdl/kmeans_lloyd_clustering.sv =====
// top level of the k-means (lloyd) clustering engine
// load items can arrive every cycle while the block is idle
// a run: copy the loaded centroids into the cells, then per pass an assign sweep,
// an accumulate sweep and a divide per centroid coordinate, then k*d output items
// at one per cycle while the sink is ready plus one flush; input is taken only while idle
// synchronous active-low reset clears control and config, stores stay undefined
`timescale 1ns / 1ps
`include "kmeans_lloyd_clustering_macros.svh"
module kmeans_lloyd_clustering #(
    parameter int MAX_POINTS   = 1024,
    parameter int MAX_CLUSTERS = 8,
    parameter int MAX_DIMS     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // load and run items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [23:0] coord
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] op
    // centroid result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [2:0] cluster, [5:3] dim_index, [29:6] coord_out
    output logic        o_m_axis_tuser,   // [0] status
    output logic        o_m_axis_tlast,
    // register writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PDEPTH = MAX_POINTS * MAX_DIMS;
    localparam int PA_W   = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int PI_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CDEPTH = MAX_CLUSTERS * MAX_DIMS;
    localparam int CA_W   = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int CL_IW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CW     = kmc_pkg::COORD_W;
    localparam int IW     = kmc_pkg::IDX_W;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_COPY   = 4'd1;
    localparam logic [3:0] S_CWAIT  = 4'd2;
    localparam logic [3:0] S_PSTART = 4'd3;
    localparam logic [3:0] S_DIST   = 4'd4;
    localparam logic [3:0] S_DWAIT  = 4'd5;
    localparam logic [3:0] S_SUM    = 4'd6;
    localparam logic [3:0] S_SWAIT  = 4'd7;
    localparam logic [3:0] S_UPD    = 4'd8;
    localparam logic [3:0] S_DIV    = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;
    localparam logic [3:0] S_OFLUSH = 4'd11;

    // config registers and their clamped copies for the run
    logic [10:0]      r_cfg_np;
    logic [3:0]       r_cfg_nk;
    logic [3:0]       r_cfg_nd;
    logic [9:0]       r_cfg_it;
    logic [CNT_W-1:0] r_n;
    logic [3:0]       r_k;
    logic [3:0]       r_dims;
    logic [9:0]       r_iter;
    logic [9:0]       r_pass;
    logic             r_status;

    logic [3:0]       r_state;

    // coordinate and assignment stores
    logic [CW-1:0]    r_pmem [PDEPTH];
    logic [CW-1:0]    r_cmem [CDEPTH];
    logic [IW-1:0]    r_amem [MAX_POINTS];
    logic [CW-1:0]    r_prd;
    logic [CW-1:0]    r_crd;
    logic [IW-1:0]    r_ard;
    logic [PA_W:0]    r_ppos;
    logic [CA_W:0]    r_cpos;

    // sweep counters
    logic [PA_W-1:0]  r_a;
    logic [PI_W-1:0]  r_p;
    logic [IW-1:0]    r_d;
    logic [IW-1:0]    r_c;
    logic [CA_W-1:0]  r_caddr;
    logic [CNT_W-1:0] r_acnt;

    // chain feed stage
    logic             r_iss_v;
    logic             r_iss_sum;
    logic             r_iss_last;
    logic [IW-1:0]    r_iss_d;

    // copy-in stage
    logic             r_cp_v;
    logic [IW-1:0]    r_cp_c;
    logic [IW-1:0]    r_cp_d;

    // output register
    logic             r_ov;
    logic [IW-1:0]    r_o_c;
    logic [IW-1:0]    r_o_d;
    logic [CW-1:0]    r_o_coord;
    logic             r_o_last;

    kmc_pkg::t_link   w_link [MAX_CLUSTERS+1];
    kmc_pkg::t_best   w_best [MAX_CLUSTERS+1];
    kmc_pkg::t_cwr    w_cwr;
    logic [CW-1:0]               w_cent [MAX_CLUSTERS];
    logic [kmc_pkg::SUM_W-1:0]   w_sum  [MAX_CLUSTERS];
    logic [CNT_W-1:0]            w_cnt  [MAX_CLUSTERS];
    logic [CW-1:0]               w_cent_sel;
    logic [kmc_pkg::SUM_W-1:0]   w_sum_sel;
    logic [CNT_W-1:0]            w_cnt_sel;

    logic             w_in_acc;
    logic             w_dlast;
    logic             w_clast;
    logic             w_plast;
    logic             w_clear;
    logic             w_div_start;
    logic             w_div_busy;
    logic             w_div_done;
    logic [CW-1:0]    w_div_q;
    logic             w_oload;
    logic             w_exit_pt;

    function automatic logic [CNT_W-1:0] clamp_n(input logic [10:0] v);
        if (v == 11'd0) begin
            return CNT_W'(1);
        end else if (int'(v) > MAX_POINTS) begin
            return CNT_W'(MAX_POINTS);
        end
        return CNT_W'(v);
    endfunction

    function automatic logic [3:0] clamp_s(input logic [3:0] v, input int hi);
        if (v == 4'd0) begin
            return 4'd1;
        end else if (int'(v) > hi) begin
            return 4'(hi);
        end
        return v;
    endfunction

    assign w_in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_dlast     = ({1'b0, r_d} == (r_dims - 4'd1));
    assign w_clast     = ({1'b0, r_c} == (r_k - 4'd1));
    assign w_plast     = (CNT_W'(r_p) == (r_n - CNT_W'(1)));
    assign w_clear     = (r_state == S_PSTART);
    assign w_cent_sel  = w_cent[r_c[CL_IW-1:0]];
    assign w_sum_sel   = w_sum[r_c[CL_IW-1:0]];
    assign w_cnt_sel   = w_cnt[r_c[CL_IW-1:0]];
    assign w_div_start = (r_state == S_UPD) && (w_cnt_sel != '0);
    assign w_oload     = (r_state == S_OUT) && (!r_ov || i_m_axis_tready);
    // one point has fully passed the last cell when its final coordinate leaves
    assign w_exit_pt   = w_link[MAX_CLUSTERS].valid && w_link[MAX_CLUSTERS].last;

    // chain feed: a coordinate from the point store, tagged with its cluster
    always_comb begin
        w_link[0].valid    = r_iss_v;
        w_link[0].mode_sum = r_iss_sum;
        w_link[0].last     = r_iss_last;
        w_link[0].dim      = r_iss_d;
        w_link[0].tag      = r_ard;
        w_link[0].coord    = r_prd;
        w_best[0]          = '0;
    end

    // centroid writes come from the copy-in sweep or from the divider
    always_comb begin
        if (r_cp_v) begin
            w_cwr.en  = 1'b1;
            w_cwr.idx = r_cp_c;
            w_cwr.dim = r_cp_d;
            w_cwr.val = r_crd;
        end else begin
            w_cwr.en  = (r_state == S_DIV) && w_div_done;
            w_cwr.idx = r_c;
            w_cwr.dim = r_d;
            w_cwr.val = w_div_q;
        end
    end

    for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
        logic w_act;
        assign w_act = (4'(g) < r_k);
        kmc_cell #(
            .CELL_IDX (g),
            .MAX_DIMS (MAX_DIMS),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_active (w_act),
            .i_clear  (w_clear),
            .i_link   (w_link[g]),
            .o_link   (w_link[g+1]),
            .i_best   (w_best[g]),
            .o_best   (w_best[g+1]),
            .i_cwr    (w_cwr),
            .i_rd_dim (r_d),
            .o_cent   (w_cent[g]),
            .o_sum    (w_sum[g]),
            .o_count  (w_cnt[g])
        );
    end

    kmc_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum_sel),
        .i_divisor  (w_cnt_sel),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_div_q)
    );

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_np <= 11'd1;
            r_cfg_nk <= 4'd1;
            r_cfg_nd <= 4'd1;
            r_cfg_it <= 10'd300;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kmc_pkg::REG_NUM_POINTS: r_cfg_np <= i_cfg_data;
                kmc_pkg::REG_NUM_CLUST:  r_cfg_nk <= i_cfg_data[3:0];
                kmc_pkg::REG_NUM_DIMS:   r_cfg_nd <= i_cfg_data[3:0];
                kmc_pkg::REG_MAX_ITER:   r_cfg_it <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // stores: point and assignment arrays, centroid array with write-back
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && w_in_acc && (i_s_axis_tuser == kmc_pkg::OP_POINT)
            && (r_ppos != (PA_W+1)'(PDEPTH))) begin
            r_pmem[r_ppos[PA_W-1:0]] <= i_s_axis_tdata;
        end
        r_prd <= r_pmem[r_a];
    end

    always_ff @(posedge i_clk) begin
        if (w_best[MAX_CLUSTERS].valid) begin
            r_amem[r_acnt[PI_W-1:0]] <= w_best[MAX_CLUSTERS].idx;
        end
        r_ard <= r_amem[r_p];
    end

    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_cmem[r_caddr] <= w_cent_sel;
        end else if ((r_state == S_IDLE) && w_in_acc
                     && (i_s_axis_tuser == kmc_pkg::OP_CENT)
                     && (r_cpos != (CA_W+1)'(CDEPTH))) begin
            r_cmem[r_cpos[CA_W-1:0]] <= i_s_axis_tdata;
        end
        r_crd <= r_cmem[r_caddr];
    end

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ppos  <= '0;
            r_cpos  <= '0;
            r_iss_v <= 1'b0;
            r_cp_v  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_iss_v <= 1'b0;
            r_cp_v  <= 1'b0;
            // count assigned points, then points whose sums left the chain
            if (w_best[MAX_CLUSTERS].valid || (w_exit_pt && w_link[MAX_CLUSTERS].mode_sum)) begin
                r_acnt <= r_acnt + CNT_W'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_s_axis_tuser)
                            kmc_pkg::OP_POINT: begin
                                if (r_ppos != (PA_W+1)'(PDEPTH)) begin
                                    r_ppos <= r_ppos + (PA_W+1)'(1);
                                end
                            end
                            kmc_pkg::OP_CENT: begin
                                if (r_cpos != (CA_W+1)'(CDEPTH)) begin
                                    r_cpos <= r_cpos + (CA_W+1)'(1);
                                end
                            end
                            kmc_pkg::OP_RUN: begin
                                r_n      <= clamp_n(r_cfg_np);
                                r_k      <= clamp_s(r_cfg_nk, MAX_CLUSTERS);
                                r_dims   <= clamp_s(r_cfg_nd, MAX_DIMS);
                                r_iter   <= r_cfg_it;
                                r_pass   <= '0;
                                r_status <= 1'b0;
                                r_c      <= '0;
                                r_d      <= '0;
                                r_caddr  <= '0;
                                r_state  <= S_COPY;
                            end
                            default: ;
                        endcase
                    end
                end
                // copy loaded centroids, row order, into the cells
                S_COPY: begin
                    r_cp_v  <= 1'b1;
                    r_cp_c  <= r_c;
                    r_cp_d  <= r_d;
                    r_caddr <= r_caddr + CA_W'(1);
                    if (w_dlast) begin
                        r_d <= '0;
                        r_c <= r_c + IW'(1);
                        if (w_clast) begin
                            r_state <= S_CWAIT;
                        end
                    end else begin
                        r_d <= r_d + IW'(1);
                    end
                end
                S_CWAIT: begin
                    if (r_iter == '0) begin
                        r_c     <= '0;
                        r_d     <= '0;
                        r_caddr <= '0;
                        r_ppos  <= '0;
                        r_cpos  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PSTART;
                    end
                end
                S_PSTART: begin
                    r_a     <= '0;
                    r_p     <= '0;
                    r_d     <= '0;
                    r_acnt  <= '0;
                    r_state <= S_DIST;
                end
                S_DIST, S_SUM: begin
                    r_iss_v    <= 1'b1;
                    r_iss_sum  <= (r_state == S_SUM);
                    r_iss_d    <= r_d;
                    r_iss_last <= w_dlast;
                    r_a        <= r_a + PA_W'(1);
                    if (w_dlast) begin
                        r_d <= '0;
                        r_p <= r_p + PI_W'(1);
                        if (w_plast) begin
                            r_state <= (r_state == S_SUM) ? S_SWAIT : S_DWAIT;
                        end
                    end else begin
                        r_d <= r_d + IW'(1);
                    end
                end
                S_DWAIT: begin
                    if (r_acnt == r_n) begin
                        r_a     <= '0;
                        r_p     <= '0;
                        r_d     <= '0;
                        r_acnt  <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SWAIT: begin
                    if (r_acnt == r_n) begin
                        r_c     <= '0;
                        r_d     <= '0;
                        r_state <= S_UPD;
                    end
                end
                // an empty cluster ends the run with the error status
                S_UPD: begin
                    if (w_cnt_sel == '0) begin
                        r_status <= 1'b1;
                        r_c      <= '0;
                        r_d      <= '0;
                        r_caddr  <= '0;
                        r_ppos   <= '0;
                        r_cpos   <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (w_dlast) begin
                            r_d <= '0;
                            if (w_clast) begin
                                r_pass <= r_pass + 10'd1;
                                if ((r_pass + 10'd1) == r_iter) begin
                                    r_c     <= '0;
                                    r_caddr <= '0;
                                    r_ppos  <= '0;
                                    r_cpos  <= '0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_PSTART;
                                end
                            end else begin
                                r_c     <= r_c + IW'(1);
                                r_state <= S_UPD;
                            end
                        end else begin
                            r_d     <= r_d + IW'(1);
                            r_state <= S_UPD;
                        end
                    end
                end
                // report centroids in row order and write them back
                S_OUT: begin
                    if (w_oload) begin
                        r_ov      <= 1'b1;
                        r_o_c     <= r_c;
                        r_o_d     <= r_d;
                        r_o_coord <= w_cent_sel;
                        r_o_last  <= w_dlast && w_clast;
                        r_caddr   <= r_caddr + CA_W'(1);
                        if (w_dlast) begin
                            r_d <= '0;
                            r_c <= r_c + IW'(1);
                            if (w_clast) begin
                                r_state <= S_OFLUSH;
                            end
                        end else begin
                            r_d <= r_d + IW'(1);
                        end
                    end
                end
                S_OFLUSH: begin
                    if (r_ov && i_m_axis_tready) begin
                        r_ov    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {2'b00, r_o_coord, r_o_d, r_o_c};
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tlast  = r_o_last;

    `KMC_ASSERT_IMP(a_in_only_when_drained, i_clk, i_rst_n, o_s_axis_tready, !o_m_axis_tvalid, "input taken while a result is pending")
    `KMC_ASSERT_IMP(a_div_start_free, i_clk, i_rst_n, w_div_start, !w_div_busy, "divider restarted while busy")
    `KMC_ASSERT_NXT(a_last_returns_idle, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast && i_m_axis_tready, r_state == S_IDLE, "run did not end after last item")
    `KMC_ASSERT_IMP(a_assign_in_dist, i_clk, i_rst_n, w_best[MAX_CLUSTERS].valid, (r_state == S_DIST) || (r_state == S_DWAIT), "assignment outside distance sweep")

endmodule
